// ===== hdl/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent basis block.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none
package ttb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FIT_BITS   = 30;
    localparam int IN_W       = 32;
    localparam int DIFF_W     = IN_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int LEN_W      = 7;
    localparam int OUT_W      = 18;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int QW         = FRAC_BITS + 1;
    localparam int NUMW       = FIT_BITS + FRAC_BITS + 1;
    localparam int EXT_W      = FRAC_BITS + 20;
    localparam int STEP_W     = 6;
    localparam int MUL_LAST   = 14;
    localparam int SQ_LAST    = 3;
    localparam int SQRT_LAST  = 31;
    localparam int DIV_LAST   = QW;
    localparam int S_DATA_W   = 160;
    localparam int M_DATA_W   = 112;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_MUL,
        ST_CHK,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MUL,
        OP_NORM,
        OP_SQ,
        OP_SQRT,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              vsel;
        logic [1:0]        comp;
        logic              deg;
        logic              load_corner;
        logic              corner_idx;
        logic              load_last;
        logic              div_last;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic vec_zero;
    } stat_t;

    // Number of significant bits of a cross-product magnitude
    function automatic logic [LEN_W-1:0] bitlen(input logic [CROSS_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < CROSS_W; i++) begin
            if (v[i]) n = LEN_W'(i + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ttb_ctrl.sv =====
// Sequencer for the triangle tangent basis block.
// Depends on ttb_pkg; drives ttb_dp through a command struct.
`default_nettype none
module ttb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ttb_pkg::stat_t stat,
    output ttb_pkg::cmd_t      cmd
);

    ttb_pkg::state_t                state_reg, state_next;
    logic [1:0]                     corner_reg, corner_next;
    logic [ttb_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           vsel_reg, vsel_next;
    logic [1:0]                     comp_reg, comp_next;
    logic                           deg_reg, deg_next;
    logic                           valid_reg, valid_next;

    // Hold state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ttb_pkg::ST_COLLECT;
            corner_reg <= '0;
            step_reg   <= '0;
            vsel_reg   <= 1'b0;
            comp_reg   <= '0;
            deg_reg    <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            step_reg   <= step_next;
            vsel_reg   <= vsel_next;
            comp_reg   <= comp_next;
            deg_reg    <= deg_next;
            valid_reg  <= valid_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb begin
        state_next  = state_reg;
        corner_next = corner_reg;
        step_next   = step_reg;
        vsel_next   = vsel_reg;
        comp_next   = comp_reg;
        deg_next    = deg_reg;
        valid_next  = valid_reg & ~m_tready;
        s_tready    = 1'b0;
        cmd             = '0;
        cmd.op          = ttb_pkg::OP_IDLE;
        cmd.step        = step_reg;
        cmd.vsel        = vsel_reg;
        cmd.comp        = comp_reg;
        cmd.deg         = deg_reg;
        cmd.corner_idx  = corner_reg[0];
        cmd.div_last    = (step_reg == ttb_pkg::STEP_W'(ttb_pkg::DIV_LAST));
        case (state_reg)
            ttb_pkg::ST_COLLECT: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (corner_reg < 2'd2) begin
                        cmd.load_corner = 1'b1;
                        corner_next     = corner_reg + 2'd1;
                    end else begin
                        cmd.load_last = 1'b1;
                        corner_next   = '0;
                        step_next     = '0;
                        deg_next      = 1'b0;
                        state_next    = ttb_pkg::ST_MUL;
                    end
                end
            end
            ttb_pkg::ST_MUL: begin
                cmd.op    = ttb_pkg::OP_MUL;
                step_next = step_reg + 1'b1;
                if (step_reg == ttb_pkg::STEP_W'(ttb_pkg::MUL_LAST)) begin
                    state_next = ttb_pkg::ST_CHK;
                end
            end
            ttb_pkg::ST_CHK: begin
                vsel_next = 1'b0;
                if (stat.det_zero) begin
                    deg_next   = 1'b1;
                    state_next = ttb_pkg::ST_OUT;
                end else begin
                    state_next = ttb_pkg::ST_NORM;
                end
            end
            ttb_pkg::ST_NORM: begin
                cmd.op    = ttb_pkg::OP_NORM;
                step_next = '0;
                if (stat.vec_zero) begin
                    deg_next   = 1'b1;
                    state_next = ttb_pkg::ST_OUT;
                end else begin
                    state_next = ttb_pkg::ST_SQ;
                end
            end
            ttb_pkg::ST_SQ: begin
                cmd.op    = ttb_pkg::OP_SQ;
                step_next = step_reg + 1'b1;
                if (step_reg == ttb_pkg::STEP_W'(ttb_pkg::SQ_LAST)) begin
                    step_next  = '0;
                    state_next = ttb_pkg::ST_SQRT;
                end
            end
            ttb_pkg::ST_SQRT: begin
                cmd.op    = ttb_pkg::OP_SQRT;
                step_next = step_reg + 1'b1;
                if (step_reg == ttb_pkg::STEP_W'(ttb_pkg::SQRT_LAST)) begin
                    step_next  = '0;
                    comp_next  = '0;
                    state_next = ttb_pkg::ST_DIV;
                end
            end
            ttb_pkg::ST_DIV: begin
                cmd.op    = ttb_pkg::OP_DIV;
                step_next = step_reg + 1'b1;
                if (cmd.div_last) begin
                    step_next = '0;
                    if (comp_reg == 2'd2) begin
                        comp_next = '0;
                        if (!vsel_reg) begin
                            vsel_next  = 1'b1;
                            state_next = ttb_pkg::ST_NORM;
                        end else begin
                            state_next = ttb_pkg::ST_OUT;
                        end
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ttb_pkg::ST_OUT: begin
                // Load the output register once it is free
                if (!valid_reg || m_tready) begin
                    cmd.op     = ttb_pkg::OP_OUT;
                    valid_next = 1'b1;
                    state_next = ttb_pkg::ST_COLLECT;
                end
            end
            default: begin
                state_next = ttb_pkg::ST_COLLECT;
            end
        endcase
    end

    assign m_tvalid = valid_reg;

endmodule
`default_nettype wire

// ===== hdl/ttb_dp.sv =====
// Datapath: held corners, shared multiplier, root and divide iterations.
// Depends on ttb_pkg; commanded by ttb_ctrl.
`default_nettype none
module ttb_dp (
    input  wire logic                           aclk,
    input  wire logic [ttb_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire ttb_pkg::cmd_t                  cmd,
    output ttb_pkg::stat_t                      stat,
    output logic [ttb_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser
);

    localparam int DW = ttb_pkg::DIFF_W;
    localparam int CW = ttb_pkg::CROSS_W;
    localparam int IW = ttb_pkg::IN_W;
    localparam int OW = ttb_pkg::OUT_W;

    logic [IW-1:0]          held_pos_reg [6];
    logic [IW-1:0]          held_tex_reg [4];
    logic signed [DW-1:0]   dp1_reg [3];
    logic signed [DW-1:0]   dp2_reg [3];
    logic signed [DW-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [ttb_pkg::PROD_W-1:0] prod_reg;
    logic signed [ttb_pkg::PROD_W-1:0] acc_reg;
    logic signed [CW-1:0]   det_reg;
    logic signed [CW-1:0]   cross_reg [6];
    logic [ttb_pkg::FIT_BITS-1:0] r_reg [3];
    logic                   sg_reg [3];
    logic [ttb_pkg::SQ_W-1:0] sum_reg, sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]            rem_reg;
    logic [ttb_pkg::QW-1:0] nsh_reg, q_reg;
    logic [OW-1:0]          res_reg [6];
    logic [ttb_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic signed [DW-1:0]   in_p [3];
    logic signed [DW-1:0]   in_u, in_v;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic [3:0]             mi;
    logic [1:0]             ci;
    logic [1:0]             sq_sel;
    logic signed [CW-1:0]   sel_c [3];
    logic [CW-1:0]          mag [3];
    logic [ttb_pkg::LEN_W-1:0] vlen, shift_k;
    logic [CW-1:0]          shifted [3];
    logic [ttb_pkg::SQ_W-1:0] sq_sum, sq_try;
    logic [ttb_pkg::ROOT_W-1:0] len;
    logic [ttb_pkg::NUMW-1:0] numer;
    logic [32:0]            rem2;
    logic                   ge;
    logic [32:0]            rem_sub;
    logic [ttb_pkg::QW-1:0] q_next;
    logic signed [ttb_pkg::EXT_W-1:0] q_ext, q_signed;
    logic [2:0]             res_idx;
    logic [2:0]             pos_base;
    logic [1:0]             tex_base;

    // Sign-extend the incoming vertex fields
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_p[i] = DW'(signed'(s_tdata[i*IW +: IW]));
        end
        in_u = DW'(signed'(s_tdata[3*IW +: IW]));
        in_v = DW'(signed'(s_tdata[4*IW +: IW]));
    end

    // Select multiplier operands for determinant terms, cross terms or squares
    always_comb begin
        mi     = cmd.step[3:0];
        ci     = 2'((mi < 4'd8) ? ((mi - 4'd2) >> 1) : ((mi - 4'd8) >> 1));
        sq_sel = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
        if (cmd.op == ttb_pkg::OP_SQ) begin
            mul_a = DW'(r_reg[sq_sel]);
            mul_b = DW'(r_reg[sq_sel]);
        end else if (mi < 4'd2) begin
            mul_a = mi[0] ? du2_reg : du1_reg;
            mul_b = mi[0] ? dv1_reg : dv2_reg;
        end else if (mi < 4'd8) begin
            mul_a = mi[0] ? dv1_reg : dv2_reg;
            mul_b = mi[0] ? dp2_reg[ci] : dp1_reg[ci];
        end else begin
            mul_a = mi[0] ? du2_reg : du1_reg;
            mul_b = mi[0] ? dp1_reg[ci] : dp2_reg[ci];
        end
    end

    // Magnitudes, common scale and reduced components of one vector; zero flags
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sel_c[i] = cmd.vsel ? cross_reg[3+i] : cross_reg[i];
            mag[i]   = sel_c[i][CW-1] ? CW'(-sel_c[i]) : CW'(sel_c[i]);
        end
        vlen    = ttb_pkg::bitlen(mag[0] | mag[1] | mag[2]);
        shift_k = (vlen > ttb_pkg::LEN_W'(ttb_pkg::FIT_BITS))
                ? vlen - ttb_pkg::LEN_W'(ttb_pkg::FIT_BITS) : '0;
        for (int i = 0; i < 3; i++) begin
            shifted[i] = mag[i] >> shift_k;
        end
        stat.vec_zero = (vlen == '0);
        stat.det_zero = (det_reg == '0);
    end

    // Root step, divide step and signed result
    always_comb begin
        sq_sum   = sum_reg + ttb_pkg::SQ_W'(prod_reg);
        sq_try   = sq_res_reg + sq_bit_reg;
        len      = sq_res_reg[ttb_pkg::ROOT_W-1:0];
        numer    = {ttb_pkg::NUMW'(r_reg[cmd.comp]) << ttb_pkg::FRAC_BITS}
                 + ttb_pkg::NUMW'(len >> 1);
        rem2     = {rem_reg, nsh_reg[ttb_pkg::QW-1]};
        ge       = (rem2 >= {1'b0, len});
        rem_sub  = rem2 - {1'b0, len};
        q_next   = {q_reg[ttb_pkg::QW-2:0], ge};
        q_ext    = {{(ttb_pkg::EXT_W - ttb_pkg::QW){1'b0}}, q_next};
        q_signed = sg_reg[cmd.comp] ? -q_ext : q_ext;
        res_idx  = cmd.vsel ? 3'(3 + cmd.comp) : 3'(cmd.comp);
        pos_base = cmd.corner_idx ? 3'd3 : 3'd0;
        tex_base = {cmd.corner_idx, 1'b0};
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        // Hold the first two corners
        if (cmd.load_corner) begin
            for (int i = 0; i < 3; i++) begin
                held_pos_reg[pos_base + 3'(i)] <= s_tdata[i*IW +: IW];
            end
            held_tex_reg[tex_base]         <= s_tdata[3*IW +: IW];
            held_tex_reg[tex_base + 2'd1]  <= s_tdata[4*IW +: IW];
        end
        // Form edge and texture deltas on the third corner
        if (cmd.load_last) begin
            for (int i = 0; i < 3; i++) begin
                dp1_reg[i] <= DW'(signed'(held_pos_reg[3+i])) - DW'(signed'(held_pos_reg[i]));
                dp2_reg[i] <= in_p[i] - DW'(signed'(held_pos_reg[i]));
            end
            du1_reg <= DW'(signed'(held_tex_reg[2])) - DW'(signed'(held_tex_reg[0]));
            dv1_reg <= DW'(signed'(held_tex_reg[3])) - DW'(signed'(held_tex_reg[1]));
            du2_reg <= in_u - DW'(signed'(held_tex_reg[0]));
            dv2_reg <= in_v - DW'(signed'(held_tex_reg[1]));
        end
        case (cmd.op)
            ttb_pkg::OP_MUL: begin
                if (cmd.step < ttb_pkg::STEP_W'(ttb_pkg::MUL_LAST)) begin
                    prod_reg <= mul_a * mul_b;
                end
                // Pair up products: keep the first, subtract the second
                if (cmd.step[0]) begin
                    acc_reg <= prod_reg;
                end else if (cmd.step != '0) begin
                    if (cmd.step == 6'd2) begin
                        det_reg <= CW'(acc_reg) - CW'(prod_reg);
                    end else begin
                        cross_reg[3'((cmd.step >> 1) - 6'd2)] <=
                            CW'(acc_reg) - CW'(prod_reg);
                    end
                end
            end
            ttb_pkg::OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    r_reg[i]  <= shifted[i][ttb_pkg::FIT_BITS-1:0];
                    sg_reg[i] <= sel_c[i][CW-1] ^ det_reg[CW-1];
                end
            end
            ttb_pkg::OP_SQ: begin
                if (cmd.step < 6'd3) begin
                    prod_reg <= mul_a * mul_b;
                end
                if (cmd.step == 6'd1) begin
                    sum_reg <= ttb_pkg::SQ_W'(prod_reg);
                end else if (cmd.step == 6'd2) begin
                    sum_reg <= sq_sum;
                end else if (cmd.step == 6'd3) begin
                    sq_v_reg   <= sq_sum;
                    sq_res_reg <= '0;
                    sq_bit_reg <= ttb_pkg::SQ_W'(1) << 62;
                end
            end
            ttb_pkg::OP_SQRT: begin
                // One result bit per step
                if (sq_v_reg >= sq_try) begin
                    sq_v_reg   <= sq_v_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ttb_pkg::OP_DIV: begin
                if (cmd.step == '0) begin
                    rem_reg <= 32'(numer[ttb_pkg::NUMW-1:ttb_pkg::QW]);
                    nsh_reg <= numer[ttb_pkg::QW-1:0];
                    q_reg   <= '0;
                end else begin
                    rem_reg <= ge ? rem_sub[31:0] : rem2[31:0];
                    nsh_reg <= nsh_reg << 1;
                    q_reg   <= q_next;
                    if (cmd.div_last) begin
                        res_reg[res_idx] <= q_signed[OW-1:0];
                    end
                end
            end
            ttb_pkg::OP_OUT: begin
                m_tuser_reg <= cmd.deg;
                if (cmd.deg) begin
                    m_tdata_reg <= '0;
                end else begin
                    m_tdata_reg <= ttb_pkg::M_DATA_W'({res_reg[5], res_reg[4], res_reg[3],
                                                      res_reg[2], res_reg[1], res_reg[0]});
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule
`default_nettype wire

// ===== hdl/triangle_tangent_basis.sv =====
// Top level of the triangle tangent basis block.
// Depends on ttb_pkg, ttb_ctrl and ttb_dp.
//
// Vertices of a triangle list enter one per item; the first two corners
// are held. The third corner starts the triangle computation and the
// input stalls until it is done: the one shared 33x33 multiplier forms
// the determinant and six cross terms, then each of the two vectors is
// scaled, its squares are summed on the multiplier, a bit-serial square
// root gives its length and three restoring divisions its components.
// The result sits in an output register, so the next triangle's first
// corners are taken while it waits. m_tuser is the degenerate flag; with
// it set all vector fields are zero.
`default_nettype none
module triangle_tangent_basis (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each, signed)
    input  wire logic [ttb_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tangent_x/y/z, bitangent_x/y/z (18 bits each, signed), 4 zero bits
    output logic [ttb_pkg::M_DATA_W-1:0]        m_tdata,
    // degenerate
    output logic                                m_tuser
);

    ttb_pkg::cmd_t  cmd;
    ttb_pkg::stat_t stat;

    ttb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttb_dp u_dp (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
`default_nettype wire

// ===== hdl/ttb_chk.sv =====
// Port checker for triangle_tangent_basis, bound to the top level.
// Depends on ttb_pkg for widths.
`default_nettype none
module ttb_chk (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [ttb_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tuser
);

    // A degenerate result carries zero vectors
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero vectors");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ttb_pkg::M_DATA_W-1:108] == '0))
        else $error("padding bits set");

endmodule

bind triangle_tangent_basis ttb_chk u_ttb_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
